// ----- rtl/assert_macros.svh -----
// Assertion helpers. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/wsd_pkg.sv -----
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int DeliverCountBitsDefault = 16;
  localparam logic [15:0] MaxPayloadReset = 16'd4095;

  localparam logic [3:0] OPC_CLOSE = 4'h8;
  localparam logic [3:0] OPC_PING  = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [2:0] KEY_BYTES = 3'd4;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_PING  = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic       last;
    logic [3:0] frame_opcode;
    logic       truncated;
  } result_t;

  typedef struct packed {
    logic [15:0] max_payload;
  } cfg_item_t;

endpackage

// ----- rtl/wsd_stream_if.sv -----
`timescale 1ns / 1ps

interface wsd_stream_if
  import wsd_pkg::*;
#(
  parameter type T = in_item_t
) ();

  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/websocket_frame_deframer.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// WebSocket receive deframer. Takes the raw receive stream one byte per
// transaction and parses each frame header (opcode, mask bit, 7/16/64-bit
// length, optional 4-byte key). Payload bytes come out unmasked, one result
// per byte, at most max_payload per frame with last on the final delivered
// byte and truncated set when the frame was longer; the rest of the frame is
// read and dropped. Close and ping frames give one event result when the
// header completes and their payload is skipped; an empty data frame gives an
// empty marker. Header bytes other than the final one give no result. Rate:
// one byte per clock, sustained; each byte is parsed in the cycle it is
// accepted and its result sits in the output register on the next cycle. The
// input stalls only while that output register holds a result that is not
// taken. max_payload should be written only between frames while idle.
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int DELIVER_COUNT_BITS = DeliverCountBitsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  wsd_stream_if.sink        in_if,
  wsd_stream_if.source      out_if,
  wsd_stream_if.sink        cfg_if
);

  localparam int CW    = DELIVER_COUNT_BITS;
  localparam int LIM_W = (CW > 16) ? CW : 16;
  localparam logic [LIM_W-1:0] CountMax = LIM_W'({CW{1'b1}});

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  phase_t       phase_r, phase_nxt;
  logic [2:0]   len_left_r, len_left_nxt;
  logic [63:0]  pay_rem_r, pay_rem_nxt;
  logic [CW-1:0] dc_r, dc_nxt;
  logic [31:0]  key_r, key_nxt;
  logic [2:0]   key_left_r, key_left_nxt;
  logic [1:0]   key_pos_r, key_pos_nxt;
  logic         mask_r, mask_nxt;
  logic [3:0]   opc_r, opc_nxt;
  logic         ctrl_r, ctrl_nxt;
  logic [15:0]  max_payload_r;

  logic         out_valid_r, out_valid_nxt;
  result_t      out_r, res;
  logic         produce;

  logic         in_ready, in_fire;
  logic [7:0]   b;
  logic         len_done, hdr_done;
  logic [2:0]   key_left_dec;
  logic [7:0]   key_byte;

  logic [LIM_W-1:0] mp_ext, lim_full;
  logic [CW-1:0]    lim, room, dc_inc;

  assign in_ready    = !out_valid_r || out_if.ready;
  assign in_if.ready = in_ready;
  assign in_fire     = in_if.valid && in_ready;
  assign b           = in_if.payload.in_byte;

  assign cfg_if.ready   = 1'b1;
  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_r;

  // Delivery limit is clipped to what the counter can hold.
  assign mp_ext   = LIM_W'(max_payload_r);
  assign lim_full = (mp_ext < CountMax) ? mp_ext : CountMax;
  assign lim      = lim_full[CW-1:0];
  assign room     = lim - dc_r;
  assign dc_inc   = dc_r + CW'(1);

  always_comb begin
    case (key_pos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    len_left_nxt = len_left_r;
    pay_rem_nxt  = pay_rem_r;
    dc_nxt       = dc_r;
    key_nxt      = key_r;
    key_left_nxt = key_left_r;
    key_pos_nxt  = key_pos_r;
    mask_nxt     = mask_r;
    opc_nxt      = opc_r;
    ctrl_nxt     = ctrl_r;
    produce      = 1'b0;
    len_done     = 1'b0;
    hdr_done     = 1'b0;
    key_left_dec = key_left_r;
    res.kind         = KIND_DATA;
    res.data_byte    = 8'h00;
    res.last         = 1'b1;
    res.frame_opcode = opc_r;
    res.truncated    = 1'b0;

    if (in_fire) begin
      unique case (phase_r)
        PH_HDR1: begin
          mask_nxt    = b[7];
          key_nxt     = 32'h0;
          pay_rem_nxt = 64'h0;
          if (b[6:0] == LEN_EXT16) begin
            len_left_nxt = 3'd1;
            phase_nxt    = PH_EXT;
          end else if (b[6:0] == LEN_EXT64) begin
            len_left_nxt = 3'd7;
            phase_nxt    = PH_EXT;
          end else begin
            pay_rem_nxt = {57'h0, b[6:0]};
            len_done    = 1'b1;
          end
        end
        PH_EXT: begin
          pay_rem_nxt = {pay_rem_r[55:0], b};
          if (len_left_r == 3'd0) begin
            len_done = 1'b1;
          end else begin
            len_left_nxt = len_left_r - 3'd1;
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], b};
          if (key_left_r != 3'd0) begin
            key_left_dec = key_left_r - 3'd1;
          end
          key_left_nxt = key_left_dec;
          if (key_left_dec == 3'd0) begin
            hdr_done = 1'b1;
          end
        end
        PH_DATA: begin
          pay_rem_nxt = pay_rem_r - 64'd1;
          if (!ctrl_r && (dc_r < lim)) begin
            produce       = 1'b1;
            dc_nxt        = dc_inc;
            key_pos_nxt   = key_pos_r + 2'd1;
            res.kind      = KIND_DATA;
            res.data_byte = b ^ key_byte;
            res.last      = (pay_rem_r == 64'd1) || (dc_inc == lim);
            res.truncated = (|pay_rem_r[63:CW]) || (pay_rem_r[CW-1:0] > room);
          end
          if (pay_rem_r == 64'd1) begin
            phase_nxt = PH_HDR0;
          end
        end
        default: begin
          // first header byte; unused phase codes land here too
          opc_nxt   = b[3:0];
          ctrl_nxt  = (b[3:0] == OPC_CLOSE) || (b[3:0] == OPC_PING);
          phase_nxt = PH_HDR1;
        end
      endcase

      if (len_done) begin
        if (mask_nxt) begin
          key_left_nxt = KEY_BYTES;
          phase_nxt    = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        key_pos_nxt = 2'd0;
        dc_nxt      = '0;
        if (ctrl_r) begin
          produce   = 1'b1;
          res.kind  = (opc_r == OPC_CLOSE) ? KIND_CLOSE : KIND_PING;
          phase_nxt = (pay_rem_nxt != 64'h0) ? PH_DATA : PH_HDR0;
        end else if (pay_rem_nxt == 64'h0) begin
          produce   = 1'b1;
          res.kind  = KIND_EMPTY;
          phase_nxt = PH_HDR0;
        end else begin
          phase_nxt = PH_DATA;
          if (lim == '0) begin
            // nothing may be delivered: mark the frame and drop its payload
            produce       = 1'b1;
            res.kind      = KIND_EMPTY;
            res.truncated = 1'b1;
          end
        end
      end
    end

    if (produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HDR0;
      len_left_r    <= 3'd0;
      pay_rem_r     <= 64'h0;
      dc_r          <= '0;
      key_r         <= 32'h0;
      key_left_r    <= 3'd0;
      key_pos_r     <= 2'd0;
      mask_r        <= 1'b0;
      opc_r         <= 4'h0;
      ctrl_r        <= 1'b0;
      max_payload_r <= MaxPayloadReset;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      len_left_r  <= len_left_nxt;
      pay_rem_r   <= pay_rem_nxt;
      dc_r        <= dc_nxt;
      key_r       <= key_nxt;
      key_left_r  <= key_left_nxt;
      key_pos_r   <= key_pos_nxt;
      mask_r      <= mask_nxt;
      opc_r       <= opc_nxt;
      ctrl_r      <= ctrl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) begin
        max_payload_r <= cfg_if.payload.max_payload;
      end
    end
    if (produce) begin
      out_r <= res;
    end
  end

  `ASSERT_IMP(a_event_last, out_valid_r && (out_r.kind != KIND_DATA), out_r.last)
  `ASSERT_IMP(a_event_no_trunc,
              out_valid_r && ((out_r.kind == KIND_CLOSE) || (out_r.kind == KIND_PING)),
              !out_r.truncated)
  `ASSERT_IMP(a_key_needs_mask, phase_r == PH_KEY, mask_r && (key_left_r != 3'd0))
  `ASSERT_NXT(a_hdr0_to_hdr1, in_fire && (phase_r == PH_HDR0), phase_r == PH_HDR1)
  `ASSERT_IMP(a_data_nonzero, phase_r == PH_DATA, pay_rem_r != 64'h0)

endmodule

// ----- verif/websocket_frame_deframer_tb.sv -----
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int COUNT_BITS = DeliverCountBitsDefault;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PRESSURE_CYCLES = 300;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int MAX_REPORTS = 10;

  localparam logic [3:0] FIN = 4'h8;
  localparam logic [3:0] OPC_CONT = 4'h0;
  localparam logic [3:0] OPC_TEXT = 4'h1;
  localparam logic [3:0] OPC_BINARY = 4'h2;
  localparam logic [3:0] OPC_PONG = 4'hA;

  typedef enum logic [2:0] {
    ST_HDR0 = 3'd0,
    ST_HDR1 = 3'd1,
    ST_EXT  = 3'd2,
    ST_KEY  = 3'd3,
    ST_DATA = 3'd4
  } parse_state_t;

  typedef enum logic [1:0] {ROW_BYTE, ROW_LIMIT} row_op_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FIXED} row_chk_t;

  typedef struct packed {
    row_op_t     op;
    logic [15:0] value;
    row_chk_t    chk;
    result_t     want;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;

  localparam stim_row_t DIRECTED [32] = '{
    // empty text frame
    '{ROW_BYTE, {8'h00, FIN, OPC_TEXT}, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0000, CHK_FIXED, '{KIND_EMPTY, 8'h00, 1'b1, OPC_TEXT, 1'b0}},
    // close with one payload byte, payload skipped
    '{ROW_BYTE, {8'h00, FIN, OPC_CLOSE}, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0001, CHK_FIXED, '{KIND_CLOSE, 8'h00, 1'b1, OPC_CLOSE, 1'b0}},
    '{ROW_BYTE, 16'h00FF, CHK_NONE, NO_RESULT},
    // empty ping
    '{ROW_BYTE, {8'h00, FIN, OPC_PING}, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0000, CHK_FIXED, '{KIND_PING, 8'h00, 1'b1, OPC_PING, 1'b0}},
    // masked binary frame, two bytes
    '{ROW_BYTE, {8'h00, FIN, OPC_BINARY}, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0082, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h00FF, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0000, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h00A5, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h005A, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h00FF, CHK_MODEL, NO_RESULT},
    '{ROW_BYTE, 16'h0055, CHK_MODEL, NO_RESULT},
    // zero limit: nonempty data frame gives a truncated empty marker
    '{ROW_LIMIT, 16'h0000, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, {8'h00, 4'h0, OPC_PONG}, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0001, CHK_FIXED, '{KIND_EMPTY, 8'h00, 1'b1, OPC_PONG, 1'b1}},
    '{ROW_BYTE, 16'h007E, CHK_NONE, NO_RESULT},
    // full limit, continuation with 16-bit length
    '{ROW_LIMIT, 16'hFFFF, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, {8'h00, FIN, OPC_CONT}, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, {8'h00, 1'b0, LEN_EXT16}, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0000, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0002, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0080, CHK_MODEL, NO_RESULT},
    '{ROW_BYTE, 16'h007F, CHK_MODEL, NO_RESULT},
    // limit dropped mid-frame to what was already delivered
    '{ROW_BYTE, {8'h00, FIN, OPC_TEXT}, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0003, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0041, CHK_MODEL, NO_RESULT},
    '{ROW_LIMIT, 16'h0001, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0042, CHK_NONE, NO_RESULT},
    '{ROW_BYTE, 16'h0043, CHK_NONE, NO_RESULT}
  };

  logic clk = 1'b0;
  logic rst_n;

  wsd_stream_if #(.T(in_item_t))  in_ch ();
  wsd_stream_if #(.T(result_t))   out_ch ();
  wsd_stream_if #(.T(cfg_item_t)) cfg_ch ();

  websocket_frame_deframer u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [15:0]  limit_cfg;
  parse_state_t parse_st;
  logic [2:0]   ext_left;
  logic [63:0]  remaining;
  logic [15:0]  delivered;
  logic [31:0]  key;
  logic [2:0]   key_left;
  logic [1:0]   key_pos;
  logic         masked;
  logic [3:0]   opcode;
  logic         ctrl;

  result_t pending_results [$];

  bit calm;
  int pressure_asked;
  int pressure_done;
  int hold_left;
  int cycles;
  int failures;
  int results_checked;
  int bytes_sent;
  int counted;
  int frames_sent;
  int limits_written;

  result_t seen;
  result_t want;

  function automatic logic [63:0] eff_limit();
    logic [63:0] cap;
    cap = (64'd1 << COUNT_BITS) - 64'd1;
    return (64'(limit_cfg) < cap) ? 64'(limit_cfg) : cap;
  endfunction

  function automatic result_t make_result(input kind_t k, input logic [7:0] d,
                                          input logic l, input logic t);
    result_t r;
    r.kind = k;
    r.data_byte = d;
    r.last = l;
    r.frame_opcode = opcode;
    r.truncated = t;
    return r;
  endfunction

  function automatic bit finish_header(output result_t r);
    r = NO_RESULT;
    key_pos = '0;
    delivered = '0;
    if (ctrl) begin
      r = make_result(opcode == OPC_CLOSE ? KIND_CLOSE : KIND_PING, 8'h00, 1'b1, 1'b0);
      parse_st = (remaining != 0) ? ST_DATA : ST_HDR0;
      return 1'b1;
    end
    if (remaining == 0) begin
      r = make_result(KIND_EMPTY, 8'h00, 1'b1, 1'b0);
      parse_st = ST_HDR0;
      return 1'b1;
    end
    parse_st = ST_DATA;
    if (eff_limit() == 0) begin
      r = make_result(KIND_EMPTY, 8'h00, 1'b1, 1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit length_complete(output result_t r);
    r = NO_RESULT;
    if (masked) begin
      key_left = KEY_BYTES;
      parse_st = ST_KEY;
      return 1'b0;
    end
    return finish_header(r);
  endfunction

  // Advances the parser by one byte.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [63:0] lim;
    logic [63:0] prior;
    logic [7:0]  k;
    logic        trunc;
    bit          has;
    r = NO_RESULT;
    has = 1'b0;
    case (parse_st)
      ST_HDR1: begin
        masked = b[7];
        key = '0;
        remaining = '0;
        if (b[6:0] == LEN_EXT16) begin
          ext_left = 3'd1;
          parse_st = ST_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          ext_left = 3'd7;
          parse_st = ST_EXT;
        end else begin
          remaining = 64'(b[6:0]);
          has = length_complete(r);
        end
      end
      ST_EXT: begin
        remaining = {remaining[55:0], b};
        if (ext_left == 0) has = length_complete(r);
        else ext_left--;
      end
      ST_KEY: begin
        key = {key[23:0], b};
        if (key_left != 0) key_left--;
        if (key_left == 0) has = finish_header(r);
      end
      ST_DATA: begin
        lim = eff_limit();
        prior = remaining;
        remaining = prior - 64'd1;
        if (!ctrl && 64'(delivered) < lim) begin
          k = 8'(key >> (24 - 8 * int'(key_pos)));
          trunc = prior > (lim - 64'(delivered));
          delivered++;
          key_pos++;
          r = make_result(KIND_DATA, b ^ k, remaining == 0 || 64'(delivered) >= lim, trunc);
          has = 1'b1;
        end
        if (remaining == 0) parse_st = ST_HDR0;
      end
      default: begin
        opcode = b[3:0];
        ctrl = (opcode == OPC_CLOSE) || (opcode == OPC_PING);
        parse_st = ST_HDR1;
      end
    endcase
    return has;
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind=%0d data=%02h last=%0d opcode=%0h trunc=%0d",
                     r.kind, r.data_byte, r.last, r.frame_opcode, r.truncated);
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic send_byte(input logic [7:0] b, input row_chk_t chk, input result_t fixed);
    result_t r;
    bit      has;
    while (!calm && $urandom_range(99) < 28) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= b;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    has = deframe_byte(b, r);
    case (chk)
      CHK_MODEL: if (has) pending_results.push_back(r);
      CHK_FIXED: pending_results.push_back(fixed);
      default: ;
    endcase
    bytes_sent++;
  endtask

  task automatic feed(input logic [7:0] b);
    send_byte(b, CHK_MODEL, NO_RESULT);
    counted++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= v;
    do @(negedge clk); while (!cfg_ch.ready);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
    limit_cfg = v;
    limits_written++;
  endtask

  // One frame, mostly well formed; a share of frames get a fully random first byte.
  task automatic send_frame();
    logic [3:0]  opc;
    logic [3:0]  flags;
    logic [7:0]  first;
    logic [6:0]  len7;
    logic [63:0] len;
    logic [31:0] k;
    bit          mask;
    int          pick;
    int          form;
    pick = $urandom_range(99);
    if (pick < 60) opc = ($urandom_range(1) != 0) ? OPC_TEXT : OPC_BINARY;
    else if (pick < 70) opc = OPC_CONT;
    else if (pick < 78) opc = OPC_CLOSE;
    else if (pick < 86) opc = OPC_PING;
    else opc = 4'($urandom_range(15));
    flags = ($urandom_range(99) < 80) ? FIN : 4'($urandom_range(15));
    first = ($urandom_range(99) < 10) ? 8'($urandom_range(255)) : {flags, opc};
    mask = $urandom_range(1);
    pick = $urandom_range(99);
    form = (pick < 75) ? 0 : (pick < 88) ? 1 : 2;
    pick = $urandom_range(99);
    if (form == 0) begin
      if (pick < 10) len = 0;
      else if (pick < 85) len = $urandom_range(1, 24);
      else len = $urandom_range(25, 125);
      len7 = len[6:0];
    end else begin
      len = (form == 1 && pick < 10) ? $urandom_range(126, 1500) : $urandom_range(0, 300);
      len7 = (form == 1) ? LEN_EXT16 : LEN_EXT64;
    end
    k = $urandom;
    feed(first);
    feed({mask, len7});
    if (form == 1) begin
      feed(len[15:8]);
      feed(len[7:0]);
    end else if (form == 2) begin
      for (int i = 7; i >= 0; i--) feed(len[8*i +: 8]);
    end
    if (mask) for (int i = 3; i >= 0; i--) feed(k[8*i +: 8]);
    for (int i = 0; i < int'(len); i++) feed(8'($urandom_range(255)));
    frames_sent++;
  endtask

  // receiver: random stalls, a long hold-off when asked, none while calm
  always @(posedge clk) begin
    if (hold_left == 0 && pressure_done < pressure_asked) begin
      hold_left = PRESSURE_CYCLES;
      pressure_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 28);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = out_ch.payload;
      results_checked++;
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result: %s", fmt_result(seen)));
      end else begin
        want = pending_results.pop_front();
        if (seen.kind !== want.kind || seen.data_byte !== want.data_byte ||
            seen.last !== want.last || seen.frame_opcode !== want.frame_opcode ||
            seen.truncated !== want.truncated)
          report_failure($sformatf("expected %s, got %s", fmt_result(want), fmt_result(seen)));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] phase_limits [PHASES];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;

    limit_cfg = MaxPayloadReset;
    parse_st = ST_HDR0;
    ext_left = '0;
    remaining = '0;
    delivered = '0;
    key = '0;
    key_left = '0;
    key_pos = '0;
    masked = 1'b0;
    opcode = '0;
    ctrl = 1'b0;

    phase_limits = '{16'd4095, 16'd0, 16'd1, 16'd3, 16'hFFFF,
                     16'($urandom_range(2, 64)), 16'($urandom_range(65535)), 16'd4095};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].op == ROW_LIMIT) write_limit(DIRECTED[i].value);
      else send_byte(DIRECTED[i].value[7:0], DIRECTED[i].chk, DIRECTED[i].want);
    end

    counted = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_limit(phase_limits[p]);
      calm = (p == 2);
      // hold the output off at full limit so the block backs up into its input
      if (p == 4) pressure_asked++;
      while (counted < (p + 1) * PHASE_ITEMS) send_frame();
    end
    calm = 1'b0;

    // 64-bit length with its top bit set: the block never leaves this frame, so it goes last
    write_limit(16'd4095);
    feed({FIN, OPC_BINARY});
    feed({1'b0, LEN_EXT64});
    feed(8'h80);
    repeat (6) feed(8'h00);
    feed(8'h02);
    repeat (3) feed(8'($urandom_range(255)));

    wait_drained();
    repeat (16) @(posedge clk);

    $display("Covered %0d bytes: directed frames plus %0d random frames over %0d limit writes.",
             bytes_sent, frames_sent, limits_written);
    $display("Checked %0d results against the predictor, %0d failures.",
             results_checked, failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
